>>> src/bmi_pkg.sv
// shared types and constants for the binary modular inverse unit
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package bmi_pkg;

   // width of one field element and of its limbs
   localparam int VAL_W      = 377;
   localparam int LIMB_W     = 64;
   localparam int TOP_LIMB_W = 57;

   // base prime of the curve, most significant limb first
   localparam logic [VAL_W-1:0] PRIME_N = {
      57'h1AE3A4617C510EA,
      64'hC63B05C06CA1493B,
      64'h1A22D9F300F5138F,
      64'h1EF3622FBA094800,
      64'h170B5D4430000000,
      64'h8508C00000000001
   };

   // controller states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_TEST = 7'b0000010,
      ST_SUBA = 7'b0000100,
      ST_SUBT = 7'b0001000,
      ST_FIXT = 7'b0010000,
      ST_HALF = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic swap;
      logic sub_a;
      logic sub_t;
      logic fix_t;
      logic halve;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic a_zero;
      logic a_odd;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/bmi_dpath.sv
// datapath of the modular inverse: working values A, B and coefficients T0, T1
// depends on bmi_pkg; driven by bmi_ctrl through dp_cmd_type
`default_nettype none

module bmi_dpath
   import bmi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   input  wire logic [VAL_W-1:0]   x_value,
   output dp_status_type           status,
   output logic [VAL_W-1:0]        result
);

   logic [VAL_W-1:0] work_a_ff, work_a_in;
   logic [VAL_W-1:0] work_b_ff, work_b_in;
   logic [VAL_W-1:0] coef_a_ff, coef_a_in;
   logic [VAL_W-1:0] coef_b_ff, coef_b_in;
   logic             borrow_ff, borrow_in;

   logic             b_above_a;
   logic [VAL_W:0]   coef_diff;
   logic [VAL_W-1:0] fix_addend;
   logic [VAL_W-1:0] half_addend;
   logic [VAL_W:0]   half_sum;

   // single wide compare, used by the swap step
   assign b_above_a = work_b_ff > work_a_ff;

   // coefficient subtract with borrow out
   assign coef_diff = {1'b0, coef_a_ff} - {1'b0, coef_b_ff};

   // add the prime back after a borrow, wrapping at the register width
   assign fix_addend = borrow_ff ? PRIME_N : '0;

   // make T0 even before halving
   assign half_addend = coef_a_ff[0] ? PRIME_N : '0;
   assign half_sum    = {1'b0, coef_a_ff} + {1'b0, half_addend};

   // next values, one step per command
   always_comb begin
      work_a_in = work_a_ff;
      work_b_in = work_b_ff;
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      borrow_in = borrow_ff;
      priority if (cmd.load) begin
         work_a_in = x_value;
         work_b_in = PRIME_N;
         coef_a_in = VAL_W'(1);
         coef_b_in = '0;
         borrow_in = 1'b0;
      end else if (cmd.swap) begin
         if (b_above_a) begin
            work_a_in = work_b_ff;
            work_b_in = work_a_ff;
            coef_a_in = coef_b_ff;
            coef_b_in = coef_a_ff;
         end
      end else if (cmd.sub_a) begin
         work_a_in = work_a_ff - work_b_ff;
      end else if (cmd.sub_t) begin
         coef_a_in = coef_diff[VAL_W-1:0];
         borrow_in = coef_diff[VAL_W];
      end else if (cmd.fix_t) begin
         coef_a_in = coef_a_ff + fix_addend;
      end else if (cmd.halve) begin
         work_a_in = {1'b0, work_a_ff[VAL_W-1:1]};
         coef_a_in = half_sum[VAL_W:1];
      end else begin
         // no command, everything holds
         borrow_in = borrow_ff;
      end
   end

   // working registers, payload only
   always_ff @(posedge clock) begin
      work_a_ff <= work_a_in;
      work_b_ff <= work_b_in;
      coef_a_ff <= coef_a_in;
      coef_b_ff <= coef_b_in;
   end

   // borrow flag between subtract and fix-up
   always_ff @(posedge clock) begin
      if (reset) begin
         borrow_ff <= 1'b0;
      end else begin
         borrow_ff <= borrow_in;
      end
   end

   assign status.a_zero = (work_a_ff == '0);
   assign status.a_odd  = work_a_ff[0];
   assign result        = coef_b_ff;

`ifndef SYNTH
   // after the swap step A is not below B
   a_sub_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.sub_a |-> (work_a_ff >= work_b_ff))
      else $error("A below B at subtraction");

   // B stays odd, so the difference is even and A odd at subtraction
   a_b_odd: assert property (@(posedge clock) disable iff (reset)
      cmd.sub_a |-> (work_b_ff[0] && work_a_ff[0]))
      else $error("operand parity wrong at subtraction");

   // the halved coefficient is reduced
   a_coef_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.halve |=> (coef_a_ff < PRIME_N))
      else $error("coefficient not reduced after halving");
`endif

endmodule

`default_nettype wire

>>> src/bmi_ctrl.sv
// controller of the modular inverse: sequences compare, subtract, fix-up and halve
// depends on bmi_pkg; commands bmi_dpath
`default_nettype none

module bmi_ctrl
   import bmi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type status,
   output logic               busy,
   output logic               rsp_valid,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.a_zero) begin
               state_in = ST_DONE;
            end else if (status.a_odd) begin
               state_in = ST_SUBA;
            end else begin
               state_in = ST_HALF;
            end
         end
         ST_SUBA: state_in = ST_SUBT;
         ST_SUBT: state_in = ST_FIXT;
         ST_FIXT: state_in = ST_HALF;
         ST_HALF: state_in = ST_TEST;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath commands
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.swap  = (state_ff == ST_TEST) && !status.a_zero && status.a_odd;
   assign cmd.sub_a = (state_ff == ST_SUBA);
   assign cmd.sub_t = (state_ff == ST_SUBT);
   assign cmd.fix_t = (state_ff == ST_FIXT);
   assign cmd.halve = (state_ff == ST_HALF);

   // handshake
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

`ifndef SYNTH
   // an accepted beat starts the loop test next cycle
   a_start_test: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_TEST))
      else $error("loop not entered after accept");

   // a result only follows a test that found A zero
   a_rsp_after_test: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff == ST_TEST) && $past(status.a_zero)))
      else $error("result without finished loop");

   // exactly one state bit is set
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");
`endif

endmodule

`default_nettype wire

>>> src/binary_modular_inverse_377_unit.sv
// top level of the modular inverse modulo the 377-bit base prime
// depends on bmi_pkg, bmi_ctrl and bmi_dpath
`default_nettype none

// Inverts a 377-bit value modulo the fixed base prime N by binary extended
// Euclid; zero and N give zero. A beat is taken when start is high and busy
// is low; busy then stays high until the result has been shown. The result
// appears on the rsp_ ports for exactly one cycle with rsp_valid and cannot be
// held off, so the receiver must take it. The loop makes passes with A even
// and passes with A odd, at most about 755 passes in all, and the unit
// returns to idle after the result before the next beat can be taken. The
// controller steps the datapath through one 377-bit operation a cycle: an
// even pass is test and halve, an odd pass is test with compare and swap,
// subtract, coefficient subtract, prime fix-up and halve.

module binary_modular_inverse_377_unit
   import bmi_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [LIMB_W-1:0]       req_x_limb0,
   input  wire logic [LIMB_W-1:0]       req_x_limb1,
   input  wire logic [LIMB_W-1:0]       req_x_limb2,
   input  wire logic [LIMB_W-1:0]       req_x_limb3,
   input  wire logic [LIMB_W-1:0]       req_x_limb4,
   input  wire logic [TOP_LIMB_W-1:0]   req_x_limb5,
   output logic                         rsp_valid,
   output logic [LIMB_W-1:0]            rsp_inv_limb0,
   output logic [LIMB_W-1:0]            rsp_inv_limb1,
   output logic [LIMB_W-1:0]            rsp_inv_limb2,
   output logic [LIMB_W-1:0]            rsp_inv_limb3,
   output logic [LIMB_W-1:0]            rsp_inv_limb4,
   output logic [TOP_LIMB_W-1:0]        rsp_inv_limb5
);

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic [VAL_W-1:0] x_value;
   logic [VAL_W-1:0] result;

   // pack the request limbs
   assign x_value = {req_x_limb5, req_x_limb4, req_x_limb3,
                     req_x_limb2, req_x_limb1, req_x_limb0};

   bmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bmi_dpath u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .x_value (x_value),
      .status  (status),
      .result  (result)
   );

   // unpack the result limbs
   assign rsp_inv_limb0 = result[LIMB_W-1:0];
   assign rsp_inv_limb1 = result[2*LIMB_W-1:LIMB_W];
   assign rsp_inv_limb2 = result[3*LIMB_W-1:2*LIMB_W];
   assign rsp_inv_limb3 = result[4*LIMB_W-1:3*LIMB_W];
   assign rsp_inv_limb4 = result[5*LIMB_W-1:4*LIMB_W];
   assign rsp_inv_limb5 = result[VAL_W-1:5*LIMB_W];

endmodule

`default_nettype wire
